// ===== rtl/core/rdr_pkg.sv =====
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared types and codes for the reliable datagram receiver.
// ----------------------------------------------------------------------------
package rdr_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_MSG  = 2'd1;
  localparam logic [1:0] KIND_REJ  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [7:0] CTRL_DATA     = 8'h00;
  localparam logic [7:0] CTRL_SETUP    = 8'h01;
  localparam logic [7:0] CTRL_TEARDOWN = 8'h02;
  localparam logic [7:0] ACK_FLAG      = 8'h01;
  localparam logic [15:0] POS_MAX      = 16'hffff;

  // sized for the largest supported payload (1024)
  localparam int OFF_W = 10;
  localparam int LEN_W = 11;

  typedef struct packed {
    logic             pull;
    logic             wr;
    logic             eod;
    logic [7:0]       data;
    logic [OFF_W-1:0] off;
    logic [31:0]      seq;
    logic [7:0]       ack;
    logic [7:0]       ctrl;
    logic             len_zero;
    logic [LEN_W-1:0] lenc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/rdr_fifo.sv =====
// ----------------------------------------------------------------------------
// rdr_fifo
// Small synchronous queue, power-of-two depth.
// ----------------------------------------------------------------------------
module rdr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wdata,
  input  logic         rd_en,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + AW'(1);
      if (rd_en) rp_r <= rp_r + AW'(1);
      if (wr_en && !rd_en) cnt_r <= cnt_r + (AW+1)'(1);
      else if (!wr_en && rd_en) cnt_r <= cnt_r - (AW+1)'(1);
    end
  end

endmodule

// ===== rtl/core/rdr_front.sv =====
// ----------------------------------------------------------------------------
// rdr_front
// Collects header bytes, tracks byte position and turns each request into
// one command for the back end.
// ----------------------------------------------------------------------------
module rdr_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic          in_opcode,
  input  logic [7:0]    in_datagram_byte,
  input  logic          in_end_of_datagram,
  input  logic          cmd_full,
  output logic          cmd_push,
  output rdr_pkg::cmd_t cmd
);
  import rdr_pkg::*;

  logic [63:0] hdr_r, hdr_nxt, hdr_w;
  logic [15:0] pos_r, pos_nxt, pos_inc, recv, lmin;
  logic        acc;

  assign full     = cmd_full;
  assign acc      = push && !cmd_full;
  assign cmd_push = acc;

  always_comb begin
    hdr_w = hdr_r;
    for (int j = 0; j < 8; j++) begin
      if (pos_r == 16'(j)) hdr_w[63-8*j -: 8] = in_datagram_byte;
    end
    pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;
    recv    = (pos_inc > 16'd8) ? pos_inc - 16'd8 : 16'd0;
    lmin    = hdr_w[15:0];
    if (lmin > recv) lmin = recv;
    if (lmin > 16'(MAX_PAYLOAD)) lmin = 16'(MAX_PAYLOAD);

    cmd.pull     = (in_opcode == OP_PULL);
    cmd.wr       = (pos_r >= 16'd8) && ((pos_r - 16'd8) < 16'(MAX_PAYLOAD));
    cmd.eod      = in_end_of_datagram;
    cmd.data     = in_datagram_byte;
    cmd.off      = OFF_W'(pos_r - 16'd8);
    cmd.seq      = hdr_w[63:32];
    cmd.ack      = hdr_w[31:24];
    cmd.ctrl     = hdr_w[23:16];
    cmd.len_zero = (hdr_w[15:0] == 16'd0);
    cmd.lenc     = LEN_W'(lmin);

    hdr_nxt = hdr_r;
    pos_nxt = pos_r;
    if (acc && in_opcode == OP_BYTE) begin
      if (in_end_of_datagram) begin
        hdr_nxt = '0;
        pos_nxt = '0;
      end else begin
        hdr_nxt = hdr_w;
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
      pos_r <= '0;
    end else begin
      hdr_r <= hdr_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/core/rdr_back.sv =====
// ----------------------------------------------------------------------------
// rdr_back
// Executes commands: payload storage, duplicate search, ACK generation and
// ordered readout of stored messages.
// ----------------------------------------------------------------------------
module rdr_back #(
  parameter int ENTRIES     = 256,
  parameter int MAX_PAYLOAD = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  rdr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output rdr_pkg::res_t res
);
  import rdr_pkg::*;

  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int IW  = $clog2(ENTRIES);
  localparam int LW  = $clog2(MAX_PAYLOAD + 1);
  localparam int OW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PD  = ENTRIES * MAX_PAYLOAD;
  localparam int PAW = $clog2(PD);

  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_RECV  = 2'd1;
  localparam logic [1:0] PH_DRAIN = 2'd2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_POST  = 3'd2;
  localparam logic [2:0] S_ACK   = 3'd3;
  localparam logic [2:0] S_ONE   = 3'd4;
  localparam logic [2:0] S_PADDR = 3'd5;
  localparam logic [2:0] S_PREAD = 3'd6;

  localparam logic [1:0] M_DUP  = 2'd0;
  localparam logic [1:0] M_FIND = 2'd1;
  localparam logic [1:0] M_LAST = 2'd2;

  logic [31:0]   seq_mem [ENTRIES];
  logic [LW-1:0] len_mem [ENTRIES];
  logic [7:0]    pay_mem [PD];
  logic [31:0]   seq_q;
  logic [LW-1:0] len_q;
  logic [7:0]    pay_q;

  logic [2:0]    st_r, st_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] dent_r, dent_nxt;
  logic [OW-1:0] doff_r, doff_nxt;
  logic [LW-1:0] dlen_r, dlen_nxt;
  logic [31:0]   dseq_r, dseq_nxt;
  logic [31:0]   lseq_r, lseq_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [CW-1:0] rdi_r, rdi_nxt;
  logic          cmpv_r, cmpv_nxt;
  logic [IW-1:0] cmpi_r, cmpi_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] besti_r, besti_nxt;
  logic [31:0]   bseq_r, bseq_nxt;
  logic [LW-1:0] blen_r, blen_nxt;
  logic [2:0]    k_r, k_nxt;
  logic          td_r, td_nxt;
  res_t          one_r, one_nxt;
  logic [PAW-1:0] paddr_r, paddr_nxt;

  logic           pwr_en, tw_en;
  logic [PAW-1:0] pwr_addr;
  logic [LW-1:0]  off_inc;
  logic [7:0]     ack_ctrl, ack_byte;
  logic           has_room;

  assign has_room = (cnt_r < CW'(ENTRIES));
  assign pwr_addr = PAW'(PAW'(cnt_r[IW-1:0]) * PAW'(MAX_PAYLOAD) + PAW'(cmd.off[OW-1:0]));
  assign off_inc  = LW'(doff_r) + LW'(1);
  assign ack_ctrl = (cmd_r.seq == 32'd0) ? CTRL_SETUP : (td_r ? CTRL_TEARDOWN : CTRL_DATA);

  always_comb begin
    case (k_r)
      3'd0:    ack_byte = cmd_r.seq[31:24];
      3'd1:    ack_byte = cmd_r.seq[23:16];
      3'd2:    ack_byte = cmd_r.seq[15:8];
      3'd3:    ack_byte = cmd_r.seq[7:0];
      3'd4:    ack_byte = ACK_FLAG;
      3'd5:    ack_byte = ack_ctrl;
      default: ack_byte = 8'h00;
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    dent_nxt  = dent_r;
    doff_nxt  = doff_r;
    dlen_nxt  = dlen_r;
    dseq_nxt  = dseq_r;
    lseq_nxt  = lseq_r;
    cmd_nxt   = cmd_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    rdi_nxt   = rdi_r;
    cmpv_nxt  = 1'b0;
    cmpi_nxt  = cmpi_r;
    found_nxt = found_r;
    besti_nxt = besti_r;
    bseq_nxt  = bseq_r;
    blen_nxt  = blen_r;
    k_nxt     = k_r;
    td_nxt    = td_r;
    one_nxt   = one_r;
    paddr_nxt = paddr_r;
    cmd_pop   = 1'b0;
    pwr_en    = 1'b0;
    tw_en     = 1'b0;
    res_push  = 1'b0;
    res       = '0;

    case (st_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          if (cmd.pull) begin
            if (phase_r != PH_DRAIN) begin
              one_nxt = '{kind: KIND_NONE, data: 8'h00, last: 1'b0};
              st_nxt  = S_ONE;
            end else if (doff_r == '0) begin
              key_nxt   = lseq_r;
              mode_nxt  = M_FIND;
              rdi_nxt   = '0;
              found_nxt = 1'b0;
              st_nxt    = S_SCAN;
            end else begin
              paddr_nxt = PAW'(PAW'(dent_r) * PAW'(MAX_PAYLOAD) + PAW'(doff_r));
              st_nxt    = S_PADDR;
            end
          end else begin
            pwr_en = cmd.wr && (phase_r == PH_RECV) && has_room;
            if (cmd.eod) begin
              case (phase_r)
                PH_SETUP: begin
                  if (cmd.ctrl == CTRL_SETUP && cmd.ack == 8'h00 && cmd.len_zero) begin
                    phase_nxt = PH_RECV;
                    td_nxt    = 1'b0;
                    k_nxt     = '0;
                    st_nxt    = S_ACK;
                  end else begin
                    one_nxt = '{kind: KIND_REJ, data: 8'h00, last: 1'b1};
                    st_nxt  = S_ONE;
                  end
                end
                PH_RECV: begin
                  if (cmd.seq != 32'd0 && cmd.ctrl != CTRL_TEARDOWN && has_room) begin
                    key_nxt   = cmd.seq;
                    mode_nxt  = M_DUP;
                    rdi_nxt   = '0;
                    found_nxt = 1'b0;
                    st_nxt    = S_SCAN;
                  end else begin
                    st_nxt = S_POST;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, compared in the cycle after
        if (rdi_r < cnt_r) begin
          rdi_nxt  = rdi_r + CW'(1);
          cmpv_nxt = 1'b1;
          cmpi_nxt = rdi_r[IW-1:0];
        end
        if (cmpv_r) begin
          if (mode_r == M_DUP) begin
            if (seq_q == key_r) found_nxt = 1'b1;
          end else if (len_q != '0 && seq_q > key_r && (!found_r || seq_q < bseq_r)) begin
            found_nxt = 1'b1;
            besti_nxt = cmpi_r;
            bseq_nxt  = seq_q;
            blen_nxt  = len_q;
          end
        end else if (rdi_r == cnt_r) begin
          case (mode_r)
            M_DUP: begin
              if (!found_r) begin
                tw_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
              st_nxt = S_POST;
            end
            M_FIND: begin
              if (!found_r) begin
                one_nxt = '{kind: KIND_NONE, data: 8'h00, last: 1'b0};
                st_nxt  = S_ONE;
              end else begin
                dent_nxt  = besti_r;
                dseq_nxt  = bseq_r;
                dlen_nxt  = blen_r;
                paddr_nxt = PAW'(PAW'(besti_r) * PAW'(MAX_PAYLOAD));
                st_nxt    = S_PADDR;
              end
            end
            default: begin
              one_nxt.kind = KIND_MSG;
              one_nxt.last = !found_r;
              st_nxt       = S_ONE;
            end
          endcase
        end
      end

      S_POST: begin
        if (cmd_r.ack == 8'h00 && cmd_r.ctrl == CTRL_DATA) begin
          td_nxt = 1'b0;
          k_nxt  = '0;
          st_nxt = S_ACK;
        end else if (cmd_r.ack == 8'h00 && cmd_r.ctrl == CTRL_TEARDOWN) begin
          phase_nxt = PH_DRAIN;
          td_nxt    = 1'b1;
          k_nxt     = '0;
          st_nxt    = S_ACK;
        end else begin
          st_nxt = S_IDLE;
        end
      end

      S_ACK: begin
        if (!res_full) begin
          res_push = 1'b1;
          res      = '{kind: KIND_ACK, data: ack_byte, last: (k_r == 3'd7)};
          k_nxt    = k_r + 3'd1;
          if (k_r == 3'd7) st_nxt = S_IDLE;
        end
      end

      S_ONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          res      = one_r;
          st_nxt   = S_IDLE;
        end
      end

      S_PADDR: begin
        st_nxt = S_PREAD;
      end

      S_PREAD: begin
        one_nxt = '{kind: KIND_MSG, data: pay_q, last: 1'b0};
        if (off_inc >= dlen_r) begin
          // message done: look ahead to flag the final byte
          lseq_nxt  = dseq_r;
          doff_nxt  = '0;
          key_nxt   = dseq_r;
          mode_nxt  = M_LAST;
          rdi_nxt   = '0;
          found_nxt = 1'b0;
          st_nxt    = S_SCAN;
        end else begin
          doff_nxt = doff_r + OW'(1);
          st_nxt   = S_ONE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwr_en) pay_mem[pwr_addr] <= cmd.data;
    if (tw_en) begin
      seq_mem[cnt_r[IW-1:0]] <= cmd_r.seq;
      len_mem[cnt_r[IW-1:0]] <= cmd_r.lenc[LW-1:0];
    end
    seq_q <= seq_mem[rdi_r[IW-1:0]];
    len_q <= len_mem[rdi_r[IW-1:0]];
    pay_q <= pay_mem[paddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      phase_r <= PH_SETUP;
      cnt_r   <= '0;
      doff_r  <= '0;
      lseq_r  <= '0;
      cmpv_r  <= 1'b0;
      found_r <= 1'b0;
      k_r     <= '0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      doff_r  <= doff_nxt;
      lseq_r  <= lseq_nxt;
      cmpv_r  <= cmpv_nxt;
      found_r <= found_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dent_r  <= dent_nxt;
    dlen_r  <= dlen_nxt;
    dseq_r  <= dseq_nxt;
    cmd_r   <= cmd_nxt;
    mode_r  <= mode_nxt;
    key_r   <= key_nxt;
    rdi_r   <= rdi_nxt;
    cmpi_r  <= cmpi_nxt;
    besti_r <= besti_nxt;
    bseq_r  <= bseq_nxt;
    blen_r  <= blen_nxt;
    td_r    <= td_nxt;
    one_r   <= one_nxt;
    paddr_r <= paddr_nxt;
  end

endmodule

// ===== rtl/core/reliable_datagram_receiver.sv =====
// ----------------------------------------------------------------------------
// reliable_datagram_receiver
// Selective-repeat datagram receiver with in-order message reassembly.
// ----------------------------------------------------------------------------
// Plain datagram bytes are taken one per cycle while the command queue has
// room and pass through it to the back end. An end of datagram in the receive
// phase may walk the sequence table once, and an ACK is 8 bytes sent one per
// cycle while the result queue has room. A pull walks the table once when a
// message starts and once more when it ends.
// Reset (rst_n low, synchronous) clears control state; the tables are not
// cleared and only entries already written are ever read.
module reliable_datagram_receiver #(
  parameter int ENTRIES     = 256,
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_opcode,
  input  logic [7:0] in_datagram_byte,
  input  logic       in_end_of_datagram,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_last
);
  import rdr_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  res_t res_in, res_out;
  logic res_push, res_full;

  rdr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk, .rst_n, .push, .full,
    .in_opcode, .in_datagram_byte, .in_end_of_datagram,
    .cmd_full, .cmd_push, .cmd(cmd_in)
  );

  rdr_fifo #(.W(CMD_W), .DEPTH(4)) u_cmd_q (
    .clk, .rst_n,
    .wr_en(cmd_push), .wdata(cmd_in),
    .rd_en(cmd_pop), .rdata(cmd_out),
    .full(cmd_full), .empty(cmd_empty)
  );

  rdr_back #(.ENTRIES(ENTRIES), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk, .rst_n,
    .cmd_empty, .cmd(cmd_out), .cmd_pop,
    .res_full, .res_push, .res(res_in)
  );

  rdr_fifo #(.W(RES_W), .DEPTH(2)) u_res_q (
    .clk, .rst_n,
    .wr_en(res_push), .wdata(res_in),
    .rd_en(pop && !empty), .rdata(res_out),
    .full(res_full), .empty(empty)
  );

  assign out_kind     = res_out.kind;
  assign out_out_byte = res_out.data;
  assign out_last     = res_out.last;

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into full queue");

  a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && (res_in.kind == KIND_REJ) |-> res_in.last)
    else $error("setup reject without last mark");

  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from empty queue");

endmodule
